@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with async reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define PBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pbc_pkg.sv @@
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared constants, types and the CRC16 byte update of the probe body checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbc_pkg;

    // Body layout
    localparam logic [3:0]  OUTER_LEN  = 4'd11;
    localparam logic [15:0] INNER_LEN  = 16'd9;
    localparam int          MAX_BLOCKS = 32;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Outer header byte positions
    localparam logic [3:0] POS_STREAM  = 4'd3;
    localparam logic [3:0] POS_LEN_LO  = 4'd4;
    localparam logic [3:0] POS_LEN_HI  = 4'd5;
    localparam logic [3:0] POS_COUNT   = 4'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd0;
    localparam logic [1:0] CFG_STREAM_ID   = 2'd1;
    localparam logic [1:0] CFG_MAGIC       = 2'd2;
    localparam logic [1:0] CFG_CRC_START   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_PAYLOAD_LEN = 16'd64;
    localparam logic [7:0]  RST_STREAM_ID   = 8'd0;
    localparam logic [15:0] RST_MAGIC       = 16'd0;
    localparam logic [15:0] RST_CRC_START   = 16'hFFFF;

    // Packed result word width (101 bits of fields, padded to bytes)
    localparam int RES_W = 104;

    // Configuration seen by the checker core
    typedef struct packed {
        logic [15:0] payload_len;
        logic [7:0]  stream_id;
        logic [15:0] magic;
        logic [15:0] crc_start;
    } cfg_t;

    // Verdict of one body
    typedef struct packed {
        logic        accepted;
        logic [31:0] sequence_res;
        logic [7:0]  profile_id;
        logic [15:0] frame_tag;
        logic [31:0] survivor_mask;
        logic [5:0]  good_blocks;
        logic [5:0]  declared_blocks;
    } verdict_t;

    // CCITT CRC16, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ src/pbc_core.sv @@
// ----------------------------------------------------------------------------
// pbc_core
// Per-body state: outer header parse, per-block CRC and inner header checks,
// survivor bookkeeping and the verdict on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  pbc_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic [7:0]        step_byte,
    input  logic              step_last,
    output pbc_pkg::verdict_t verdict
);

    logic [3:0]  outer_pos_reg,   outer_pos_next;
    logic [15:0] wire_len_reg,    wire_len_next;
    logic [7:0]  wire_count_reg,  wire_count_next;
    logic [5:0]  block_index_reg, block_index_next;
    logic [16:0] block_offset_reg, block_offset_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] carried_crc_reg, carried_crc_next;
    logic [55:0] cur_hdr_reg,     cur_hdr_next;
    logic [55:0] kept_hdr_reg,    kept_hdr_next;
    logic        have_surv_reg,   have_surv_next;
    logic [31:0] mask_reg,        mask_next;
    logic [5:0]  good_reg,        good_next;
    logic        rejected_reg,    rejected_next;
    logic        magic_ok_reg,    magic_ok_next;

    logic        block_end;
    logic        block_ok;
    logic        body_ok;

    // Byte step: outer header, then block CRC / magic / inner header capture
    always_comb
    begin
        outer_pos_next    = outer_pos_reg;
        wire_len_next     = wire_len_reg;
        wire_count_next   = wire_count_reg;
        block_index_next  = block_index_reg;
        block_offset_next = block_offset_reg;
        running_crc_next  = running_crc_reg;
        carried_crc_next  = carried_crc_reg;
        cur_hdr_next      = cur_hdr_reg;
        kept_hdr_next     = kept_hdr_reg;
        have_surv_next    = have_surv_reg;
        mask_next         = mask_reg;
        good_next         = good_reg;
        rejected_next     = rejected_reg;
        magic_ok_next     = magic_ok_reg;
        block_end         = 1'b0;
        block_ok          = 1'b0;

        if (!rejected_reg) begin
            if (outer_pos_reg < pbc_pkg::OUTER_LEN) begin
                if (outer_pos_reg == pbc_pkg::POS_STREAM && step_byte != cfg.stream_id) begin
                    rejected_next = 1'b1;
                end
                if (outer_pos_reg == pbc_pkg::POS_LEN_LO) begin
                    wire_len_next = {8'h00, step_byte};
                end
                if (outer_pos_reg == pbc_pkg::POS_LEN_HI) begin
                    wire_len_next = {step_byte, wire_len_reg[7:0]};
                    if ({step_byte, wire_len_reg[7:0]} != cfg.payload_len) begin
                        rejected_next = 1'b1;
                    end
                end
                if (outer_pos_reg == pbc_pkg::POS_COUNT) begin
                    wire_count_next = step_byte;
                    if (step_byte < 8'd1 || step_byte > 8'(pbc_pkg::MAX_BLOCKS)) begin
                        rejected_next = 1'b1;
                    end
                end
                outer_pos_next = outer_pos_reg + 4'd1;
                if (outer_pos_reg == pbc_pkg::OUTER_LEN - 4'd1) begin
                    running_crc_next = cfg.crc_start;
                    magic_ok_next    = 1'b1;
                end
            end else if ({2'b00, block_index_reg} < wire_count_reg) begin
                // carried CRC, little-endian, then payload bytes
                if (block_offset_reg == 17'd0) begin
                    carried_crc_next = {8'h00, step_byte};
                end else if (block_offset_reg == 17'd1) begin
                    carried_crc_next = {step_byte, carried_crc_reg[7:0]};
                end else begin
                    running_crc_next = pbc_pkg::crc_byte(running_crc_reg, step_byte);
                    if (block_offset_reg == 17'd2 && step_byte != cfg.magic[7:0]) begin
                        magic_ok_next = 1'b0;
                    end
                    if (block_offset_reg == 17'd3 && step_byte != cfg.magic[15:8]) begin
                        magic_ok_next = 1'b0;
                    end
                    // inner header = payload bytes 2..8
                    for (int k = 0; k < 7; k++) begin
                        if (block_offset_reg == 17'(k + 4)) begin
                            cur_hdr_next[k*8 +: 8] = step_byte;
                        end
                    end
                end

                block_end = (block_offset_reg == ({1'b0, wire_len_reg} + 17'd1));
                if (block_end) begin
                    block_ok = (running_crc_next == carried_crc_next) && magic_ok_next &&
                               (wire_len_reg >= pbc_pkg::INNER_LEN);
                    if (block_ok) begin
                        if (have_surv_reg && kept_hdr_reg != cur_hdr_next) begin
                            rejected_next = 1'b1;
                        end else begin
                            kept_hdr_next  = cur_hdr_next;
                            have_surv_next = 1'b1;
                            mask_next      = mask_reg | (32'd1 << block_index_reg[4:0]);
                            good_next      = good_reg + 6'd1;
                        end
                    end
                    block_index_next  = block_index_reg + 6'd1;
                    block_offset_next = 17'd0;
                    running_crc_next  = cfg.crc_start;
                    carried_crc_next  = 16'd0;
                    cur_hdr_next      = 56'd0;
                    magic_ok_next     = 1'b1;
                end else begin
                    block_offset_next = block_offset_reg + 17'd1;
                end
            end
        end

        body_ok = !rejected_next && (outer_pos_next == pbc_pkg::OUTER_LEN) &&
                  ({2'b00, block_index_next} == wire_count_next) && have_surv_next;
    end

    // Verdict fields, all zero on rejection
    always_comb
    begin
        verdict = '0;
        if (body_ok) begin
            verdict.accepted        = 1'b1;
            verdict.sequence_res    = kept_hdr_next[31:0];
            verdict.profile_id      = kept_hdr_next[39:32];
            verdict.frame_tag       = kept_hdr_next[55:40];
            verdict.survivor_mask   = mask_next;
            verdict.good_blocks     = good_next;
            verdict.declared_blocks = wire_count_next[5:0];
        end
    end

    // State registers; the final byte returns all body state to its start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            outer_pos_reg    <= '0;
            wire_len_reg     <= '0;
            wire_count_reg   <= '0;
            block_index_reg  <= '0;
            block_offset_reg <= '0;
            running_crc_reg  <= pbc_pkg::RST_CRC_START;
            carried_crc_reg  <= '0;
            cur_hdr_reg      <= '0;
            kept_hdr_reg     <= '0;
            have_surv_reg    <= 1'b0;
            mask_reg         <= '0;
            good_reg         <= '0;
            rejected_reg     <= 1'b0;
            magic_ok_reg     <= 1'b1;
        end else if (step) begin
            if (step_last) begin
                outer_pos_reg    <= '0;
                wire_len_reg     <= '0;
                wire_count_reg   <= '0;
                block_index_reg  <= '0;
                block_offset_reg <= '0;
                running_crc_reg  <= cfg.crc_start;
                carried_crc_reg  <= '0;
                cur_hdr_reg      <= '0;
                kept_hdr_reg     <= '0;
                have_surv_reg    <= 1'b0;
                mask_reg         <= '0;
                good_reg         <= '0;
                rejected_reg     <= 1'b0;
                magic_ok_reg     <= 1'b1;
            end else begin
                outer_pos_reg    <= outer_pos_next;
                wire_len_reg     <= wire_len_next;
                wire_count_reg   <= wire_count_next;
                block_index_reg  <= block_index_next;
                block_offset_reg <= block_offset_next;
                running_crc_reg  <= running_crc_next;
                carried_crc_reg  <= carried_crc_next;
                cur_hdr_reg      <= cur_hdr_next;
                kept_hdr_reg     <= kept_hdr_next;
                have_surv_reg    <= have_surv_next;
                mask_reg         <= mask_next;
                good_reg         <= good_next;
                rejected_reg     <= rejected_next;
                magic_ok_reg     <= magic_ok_next;
            end
        end
    end

    // Checks
    `PBC_ASSERT_NEXT(a_body_cleared, step && step_last,
        outer_pos_reg == 4'd0 && block_index_reg == 6'd0 && !rejected_reg,
        "body state not cleared after final word")
    `PBC_ASSERT_SAME(a_survivor_mask, 1'b1, have_surv_reg == (mask_reg != 32'd0),
        "survivor flag and mask disagree")
    `PBC_ASSERT_SAME(a_good_count, 1'b1, {26'd0, good_reg} == 32'($countones(mask_reg)),
        "survivor count differs from mask")

endmodule

@@ src/probe_body_checker_unit.sv @@
// ----------------------------------------------------------------------------
// probe_body_checker_unit
// Probe body checker: one body byte per word in, one verdict word per body.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one body byte per word in s_axis_tdata, s_axis_tlast on the
//   final byte of a body. Every final byte yields exactly one verdict word on
//   the master stream; other bytes yield none.
//   Config channel: cfg_index selects the register (0 payload length,
//   1 stream id, 2 magic, 3 CRC start), cfg_data carries the value; cfg_ready
//   is always high. Write only while no body is in progress.
//   Throughput: one byte per cycle, sustained, while no final byte waits on
//   a held verdict. Each byte passes an input register and then the per-byte
//   logic (CRC16 byte update and header compare); a verdict is captured in the
//   output register and shows on m_axis_tvalid after its final byte is taken.
//   Stall: a held verdict in the output register blocks the next final byte,
//   and bytes behind it wait too; bytes ahead of it flow while m_axis_tready is low.
//   Reset: rst_n clears all body state and loads the register defaults
//   (length 64, stream id 0, magic 0, CRC start 0xFFFF).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module probe_body_checker_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    // slave stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] body_byte
    input  logic                      s_axis_tlast,   // final_byte
    // master stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] accepted, [32:1] sequence_res, [40:33] profile_id, [56:41] frame_tag,
    // [88:57] survivor_mask, [94:89] good_blocks, [100:95] declared_blocks,
    // [103:101] zero
    output logic [pbc_pkg::RES_W-1:0] m_axis_tdata,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);

    pbc_pkg::cfg_t     cfg_reg;
    pbc_pkg::verdict_t verdict;

    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_last_reg;
    logic        advance;
    logic        out_valid_reg;
    logic [pbc_pkg::RES_W-1:0] out_data_reg;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.payload_len <= pbc_pkg::RST_PAYLOAD_LEN;
            cfg_reg.stream_id   <= pbc_pkg::RST_STREAM_ID;
            cfg_reg.magic       <= pbc_pkg::RST_MAGIC;
            cfg_reg.crc_start   <= pbc_pkg::RST_CRC_START;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pbc_pkg::CFG_PAYLOAD_LEN: cfg_reg.payload_len <= cfg_data;
                pbc_pkg::CFG_STREAM_ID:   cfg_reg.stream_id   <= cfg_data[7:0];
                pbc_pkg::CFG_MAGIC:       cfg_reg.magic       <= cfg_data;
                pbc_pkg::CFG_CRC_START:   cfg_reg.crc_start   <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input register; a final byte waits only while the verdict slot is full
    assign advance       = stg_valid_reg && (!stg_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stg_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            stg_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            stg_byte_reg <= s_axis_tdata;
            stg_last_reg <= s_axis_tlast;
        end
    end

    // Body checker
    pbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (advance),
        .step_byte (stg_byte_reg),
        .step_last (stg_last_reg),
        .verdict   (verdict)
    );

    // Verdict output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && stg_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stg_last_reg) begin
            out_data_reg <= {3'b000,
                             verdict.declared_blocks,
                             verdict.good_blocks,
                             verdict.survivor_mask,
                             verdict.frame_tag,
                             verdict.profile_id,
                             verdict.sequence_res,
                             verdict.accepted};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    `PBC_ASSERT_SAME(a_reject_zero, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[100:1] == 100'd0, "rejected verdict carries nonzero fields")
    `PBC_ASSERT_NEXT(a_final_waits,
        stg_valid_reg && stg_last_reg && out_valid_reg && !m_axis_tready,
        stg_valid_reg && stg_last_reg, "final byte dropped while verdict stalled")

endmodule

@@ tb/probe_body_checker_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_body_checker_unit_tb
// Self-checking bench for the probe body checker. Bodies are built byte by
// byte from the current register settings (headers, CRC16 blocks, magic and
// inner headers, with chosen faults), streamed in as words, and every verdict
// word is compared with a cycle-free model of the checker or a row's verdict.
// A directed table comes first, then random bodies under four idle patterns.
// ----------------------------------------------------------------------------

module probe_body_checker_unit_tb;

    // Kind of fault placed in the outer header
    typedef enum int {HF_NONE, HF_STREAM, HF_LEN, HF_COUNT} hdr_fault_t;

    // Register set used by a directed row
    typedef enum int {SET_RESET, SET_MIN, SET_MAX, SET_MID} reg_set_t;

    // How the expected verdict of a directed row is obtained
    typedef enum int {EXP_MODEL, EXP_REJECT, EXP_SINGLE} want_t;

    typedef struct {
        hdr_fault_t  hf;
        int          nblk;       // wire block count
        logic [31:0] crc_bad;    // per block: corrupt carried CRC
        logic [31:0] magic_bad;  // per block: corrupt a magic byte
        logic [31:0] hdr_diff;   // per block: inner header differs
        int          trail;      // bytes after the last block
        int          cut;        // 0: whole body, else body length
        logic [31:0] seq;
        logic [7:0]  prof;
        logic [15:0] tag;
    } body_desc_t;

    typedef struct {
        reg_set_t   rset;
        body_desc_t body;
        want_t      want;
    } dir_row_t;

    localparam int DIR_ROWS    = 20;
    localparam int SETTLE_MAX  = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [pbc_pkg::RES_W-1:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = pbc_pkg::CFG_PAYLOAD_LEN;
    logic [15:0] cfg_data = 16'h0000;

    probe_body_checker_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Register copies as the checker should hold them
    logic [15:0] r_len   = pbc_pkg::RST_PAYLOAD_LEN;
    logic [7:0]  r_sid   = pbc_pkg::RST_STREAM_ID;
    logic [15:0] r_magic = pbc_pkg::RST_MAGIC;
    logic [15:0] r_crc0  = pbc_pkg::RST_CRC_START;

    // Per-body state of the verdict model
    logic [3:0]  p_outer;
    logic [15:0] p_wlen;
    logic [7:0]  p_wcnt;
    logic [5:0]  p_blk;
    logic [16:0] p_off;
    logic [15:0] p_crc;
    logic [15:0] p_carried;
    logic [55:0] p_cur;
    logic [55:0] p_kept;
    logic        p_have;
    logic        p_rejected;
    logic        p_magic_ok;
    logic [31:0] p_mask;
    logic [5:0]  p_good;

    pbc_pkg::verdict_t pending_verdicts [$];
    pbc_pkg::verdict_t typed_verdict;
    logic              use_typed = 1'b0;
    pbc_pkg::verdict_t head_verdict;
    logic [7:0]  body_q [$];
    dir_row_t    dir_tab [DIR_ROWS];
    int          fail_count = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;

    // CCITT CRC16, MSB first, one byte
    function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] d);
        logic fb;
        int   i;
        for (i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? pbc_pkg::CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic dir_row_t mk_row(input reg_set_t rset, input hdr_fault_t hf,
                                        input int nblk, input logic [31:0] crc_bad,
                                        input logic [31:0] magic_bad,
                                        input logic [31:0] hdr_diff, input int trail,
                                        input int cut, input logic [31:0] seq,
                                        input logic [7:0] prof, input logic [15:0] tag,
                                        input want_t want);
        dir_row_t r;
        r.rset           = rset;
        r.body.hf        = hf;
        r.body.nblk      = nblk;
        r.body.crc_bad   = crc_bad;
        r.body.magic_bad = magic_bad;
        r.body.hdr_diff  = hdr_diff;
        r.body.trail     = trail;
        r.body.cut       = cut;
        r.body.seq       = seq;
        r.body.prof      = prof;
        r.body.tag       = tag;
        r.want           = want;
        return r;
    endfunction

    task automatic clear_body_state();
        p_outer    = '0;
        p_wlen     = '0;
        p_wcnt     = '0;
        p_blk      = '0;
        p_off      = '0;
        p_crc      = r_crc0;
        p_carried  = '0;
        p_cur      = '0;
        p_kept     = '0;
        p_have     = 1'b0;
        p_rejected = 1'b0;
        p_magic_ok = 1'b1;
        p_mask     = '0;
        p_good     = '0;
    endtask

    // Verdict model: takes one byte, gives the verdict when is_last is set
    task automatic absorb_byte(input logic [7:0] b, input logic is_last,
                               output pbc_pkg::verdict_t v);
        logic [16:0] p;
        logic [5:0]  sh;
        v = '0;
        if (!p_rejected) begin
            if (p_outer < pbc_pkg::OUTER_LEN) begin
                // outer header
                if (p_outer == pbc_pkg::POS_STREAM && b != r_sid)
                    p_rejected = 1'b1;
                if (p_outer == pbc_pkg::POS_LEN_LO)
                    p_wlen = {8'h00, b};
                if (p_outer == pbc_pkg::POS_LEN_HI) begin
                    p_wlen[15:8] = b;
                    if (p_wlen != r_len)
                        p_rejected = 1'b1;
                end
                if (p_outer == pbc_pkg::POS_COUNT) begin
                    p_wcnt = b;
                    if (b < 8'd1 || b > 8'(pbc_pkg::MAX_BLOCKS))
                        p_rejected = 1'b1;
                end
                p_outer = p_outer + 4'd1;
                if (p_outer == pbc_pkg::OUTER_LEN) begin
                    p_crc      = r_crc0;
                    p_magic_ok = 1'b1;
                end
            end
            else if ({2'b00, p_blk} < p_wcnt) begin
                // block: CRC low, CRC high, then payload
                if (p_off == 17'd0)
                    p_carried = {8'h00, b};
                else if (p_off == 17'd1)
                    p_carried[15:8] = b;
                else begin
                    p = p_off - 17'd2;
                    p_crc = ccitt_step(p_crc, b);
                    if (p == 17'd0 && b != r_magic[7:0])
                        p_magic_ok = 1'b0;
                    if (p == 17'd1 && b != r_magic[15:8])
                        p_magic_ok = 1'b0;
                    if (p >= 17'd2 && p < 17'(pbc_pkg::INNER_LEN)) begin
                        sh = 6'(p - 17'd2) << 3;
                        p_cur[sh +: 8] = b;
                    end
                end
                if (p_off == {1'b0, p_wlen} + 17'd1) begin
                    // block end: survivor check and agreement
                    if (p_crc == p_carried && p_magic_ok && p_wlen >= pbc_pkg::INNER_LEN) begin
                        if (p_have && p_kept != p_cur)
                            p_rejected = 1'b1;
                        else begin
                            p_kept            = p_cur;
                            p_have            = 1'b1;
                            p_mask[p_blk[4:0]] = 1'b1;
                            p_good            = p_good + 6'd1;
                        end
                    end
                    p_blk      = p_blk + 6'd1;
                    p_off      = '0;
                    p_crc      = r_crc0;
                    p_carried  = '0;
                    p_cur      = '0;
                    p_magic_ok = 1'b1;
                end
                else
                    p_off = p_off + 17'd1;
            end
        end
        if (is_last) begin
            if (!p_rejected && p_outer == pbc_pkg::OUTER_LEN && {2'b00, p_blk} == p_wcnt
                && p_have) begin
                v.accepted        = 1'b1;
                v.sequence_res    = p_kept[31:0];
                v.profile_id      = p_kept[39:32];
                v.frame_tag       = p_kept[55:40];
                v.survivor_mask   = p_mask;
                v.good_blocks     = p_good;
                v.declared_blocks = p_wcnt[5:0];
            end
            clear_body_state();
        end
    endtask

    // Fill body_q with one body built from the current register copies
    task automatic build_body(input body_desc_t d);
        logic [7:0]  pl [$];
        logic [15:0] crc;
        logic [15:0] wlen;
        int          nb;
        int          k;
        int          j;
        int          at;
        body_q.delete();
        wlen = r_len;
        if (d.hf == HF_LEN)
            wlen = r_len ^ 16'($urandom_range(1, 65535));
        for (k = 0; k < pbc_pkg::OUTER_LEN; k++)
            body_q.insert(body_q.size(), 8'($urandom_range(255)));
        body_q[pbc_pkg::POS_STREAM] = r_sid;
        if (d.hf == HF_STREAM)
            body_q[pbc_pkg::POS_STREAM] = r_sid ^ 8'($urandom_range(1, 255));
        body_q[pbc_pkg::POS_LEN_LO] = wlen[7:0];
        body_q[pbc_pkg::POS_LEN_HI] = wlen[15:8];
        body_q[pbc_pkg::POS_COUNT]  = 8'(d.nblk);
        nb = (d.nblk >= 1 && d.nblk <= pbc_pkg::MAX_BLOCKS) ? d.nblk : 1;
        for (k = 0; k < nb; k++) begin
            pl.delete();
            pl.insert(pl.size(), r_magic[7:0]);
            pl.insert(pl.size(), r_magic[15:8]);
            for (j = 0; j < 4; j++)
                pl.insert(pl.size(), d.seq[8 * j +: 8]);
            pl.insert(pl.size(), d.prof);
            pl.insert(pl.size(), d.tag[7:0]);
            pl.insert(pl.size(), d.tag[15:8]);
            while (pl.size() < r_len)
                pl.insert(pl.size(), 8'($urandom_range(255)));
            if (d.magic_bad[k]) begin
                at = $urandom_range(1);
                pl[at] = pl[at] ^ 8'($urandom_range(1, 255));
            end
            if (d.hdr_diff[k]) begin
                at = $urandom_range(2, 8);
                pl[at] = pl[at] ^ 8'($urandom_range(1, 255));
            end
            crc = r_crc0;
            for (j = 0; j < pl.size(); j++)
                crc = ccitt_step(crc, pl[j]);
            if (d.crc_bad[k])
                crc = crc ^ 16'($urandom_range(1, 65535));
            body_q.insert(body_q.size(), crc[7:0]);
            body_q.insert(body_q.size(), crc[15:8]);
            for (j = 0; j < pl.size(); j++)
                body_q.insert(body_q.size(), pl[j]);
        end
        for (k = 0; k < d.trail; k++)
            body_q.insert(body_q.size(), 8'($urandom_range(255)));
        if (d.cut > 0)
            while (body_q.size() > d.cut)
                void'(body_q.pop_back());
    endtask

    // One word on the slave stream, with random sender gaps
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        int                gap;
        pbc_pkg::verdict_t v;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_byte(b, is_last, v);
        if (is_last)
            pending_verdicts.insert(pending_verdicts.size(), use_typed ? typed_verdict : v);
    endtask

    task automatic send_body();
        int i;
        for (i = 0; i < body_q.size(); i++)
            push_byte(body_q[i], i == body_q.size() - 1);
    endtask

    // Hold the sender until every verdict is out, then let the pipe empty
    task automatic settle();
        int n;
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < SETTLE_MAX && pending_verdicts.size() != 0; n++)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pbc_pkg::CFG_PAYLOAD_LEN: r_len   = val;
            pbc_pkg::CFG_STREAM_ID:   r_sid   = val[7:0];
            pbc_pkg::CFG_MAGIC:       r_magic = val;
            pbc_pkg::CFG_CRC_START:   r_crc0  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] len, input logic [7:0] sid,
                                input logic [15:0] magic, input logic [15:0] crc0);
        settle();
        cfg_put(pbc_pkg::CFG_PAYLOAD_LEN, len);
        cfg_put(pbc_pkg::CFG_STREAM_ID, {8'h00, sid});
        cfg_put(pbc_pkg::CFG_MAGIC, magic);
        cfg_put(pbc_pkg::CFG_CRC_START, crc0);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random stalls, check each verdict word against the oldest one
    always @(posedge clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict word with none expected, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else begin
                head_verdict = pending_verdicts.pop_front();
                compare_field("accepted", 32'(head_verdict.accepted), 32'(m_axis_tdata[0]));
                compare_field("sequence_res", head_verdict.sequence_res,
                              m_axis_tdata[32:1]);
                compare_field("profile_id", 32'(head_verdict.profile_id),
                              32'(m_axis_tdata[40:33]));
                compare_field("frame_tag", 32'(head_verdict.frame_tag),
                              32'(m_axis_tdata[56:41]));
                compare_field("survivor_mask", head_verdict.survivor_mask,
                              m_axis_tdata[88:57]);
                compare_field("good_blocks", 32'(head_verdict.good_blocks),
                              32'(m_axis_tdata[94:89]));
                compare_field("declared_blocks", 32'(head_verdict.declared_blocks),
                              32'(m_axis_tdata[100:95]));
            end
        end
    end

    // Main sequence
    initial begin
        body_desc_t d;
        int         i;
        int         k;
        int         r;
        int         ph;
        int         ph_bytes;
        int         ph_bodies;
        logic       held;
        reg_set_t   cur_set;

        clear_body_state();

        // Directed bodies
        dir_tab[0]  = mk_row(SET_RESET, HF_NONE, 1, 0, 0, 0, 0, 0,
                             32'h01020304, 8'h55, 16'hBEEF, EXP_SINGLE);
        dir_tab[1]  = mk_row(SET_RESET, HF_STREAM, 1, 0, 0, 0, 0, 0,
                             32'h0, 8'h0, 16'h0, EXP_REJECT);
        dir_tab[2]  = mk_row(SET_MIN, HF_NONE, 32, 0, 0, 0, 0, 0,
                             32'hFFFFFFFF, 8'hFF, 16'hFFFF, EXP_MODEL);
        dir_tab[3]  = mk_row(SET_MIN, HF_COUNT, 0, 0, 0, 0, 0, 0,
                             32'h0, 8'h0, 16'h0, EXP_REJECT);
        dir_tab[4]  = mk_row(SET_MIN, HF_COUNT, 33, 0, 0, 0, 0, 0,
                             32'h0, 8'h0, 16'h0, EXP_REJECT);
        dir_tab[5]  = mk_row(SET_MIN, HF_COUNT, 255, 0, 0, 0, 0, 0,
                             32'h0, 8'h0, 16'h0, EXP_REJECT);
        dir_tab[6]  = mk_row(SET_MIN, HF_LEN, 1, 0, 0, 0, 0, 0,
                             32'h0, 8'h0, 16'h0, EXP_REJECT);
        dir_tab[7]  = mk_row(SET_MIN, HF_NONE, 3, 32'b010, 0, 0, 0, 0,
                             32'h89ABCDEF, 8'h12, 16'h3456, EXP_MODEL);
        dir_tab[8]  = mk_row(SET_MIN, HF_NONE, 4, 0, 32'b0101, 0, 0, 0,
                             32'h00000000, 8'h00, 16'h0000, EXP_MODEL);
        dir_tab[9]  = mk_row(SET_MIN, HF_NONE, 3, 0, 0, 32'b100, 0, 0,
                             32'h13572468, 8'h9A, 16'h0102, EXP_REJECT);
        // differing header hidden behind a bad CRC: body still passes
        dir_tab[10] = mk_row(SET_MIN, HF_NONE, 3, 32'b010, 0, 32'b010, 0, 0,
                             32'h55AA55AA, 8'hA5, 16'h5A5A, EXP_MODEL);
        dir_tab[11] = mk_row(SET_MIN, HF_NONE, 2, 32'b11, 0, 0, 0, 0,
                             32'h1, 8'h1, 16'h1, EXP_REJECT);
        dir_tab[12] = mk_row(SET_MIN, HF_NONE, 2, 0, 0, 0, 0, 30,
                             32'h2, 8'h2, 16'h2, EXP_REJECT);
        dir_tab[13] = mk_row(SET_MIN, HF_NONE, 1, 0, 0, 0, 0, 1,
                             32'h3, 8'h3, 16'h3, EXP_REJECT);
        dir_tab[14] = mk_row(SET_MIN, HF_NONE, 1, 0, 0, 0, 0, 7,
                             32'h4, 8'h4, 16'h4, EXP_REJECT);
        dir_tab[15] = mk_row(SET_MIN, HF_NONE, 1, 0, 0, 0, 5, 0,
                             32'hCAFEF00D, 8'h77, 16'h8001, EXP_MODEL);
        dir_tab[16] = mk_row(SET_MIN, HF_NONE, 5, 0, 0, 32'b00001, 0, 0,
                             32'h5, 8'h5, 16'h5, EXP_REJECT);
        dir_tab[17] = mk_row(SET_MAX, HF_NONE, 1, 0, 0, 0, 0, 40,
                             32'h6, 8'h6, 16'h6, EXP_REJECT);
        dir_tab[18] = mk_row(SET_MAX, HF_LEN, 1, 0, 0, 0, 0, 20,
                             32'h7, 8'h7, 16'h7, EXP_REJECT);
        dir_tab[19] = mk_row(SET_MID, HF_NONE, 6, 32'b100001, 32'b000100, 0, 2, 0,
                             32'h00000000, 8'h00, 16'h0000, EXP_MODEL);

        // Reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct  = 20;
        rcv_stall_pct = 20;
        cur_set = SET_RESET;
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].rset != cur_set) begin
                cur_set = dir_tab[i].rset;
                case (cur_set)
                    SET_MIN: program_regs(16'd9, 8'hFF, 16'hFFFF, 16'h0000);
                    SET_MAX: program_regs(16'hFFFF, 8'hA5, 16'h0000, 16'hFFFF);
                    SET_MID: program_regs(16'd20, 8'h3C, 16'h1234, 16'h1D0F);
                    default: ;
                endcase
            end
            build_body(dir_tab[i].body);
            typed_verdict = '0;
            if (dir_tab[i].want == EXP_SINGLE) begin
                typed_verdict.accepted        = 1'b1;
                typed_verdict.sequence_res    = dir_tab[i].body.seq;
                typed_verdict.profile_id      = dir_tab[i].body.prof;
                typed_verdict.frame_tag       = dir_tab[i].body.tag;
                typed_verdict.survivor_mask   = 32'h1;
                typed_verdict.good_blocks     = 6'd1;
                typed_verdict.declared_blocks = 6'd1;
            end
            use_typed = (dir_tab[i].want != EXP_MODEL);
            send_body();
            use_typed = 1'b0;
        end

        // Random bodies, one idle pattern per phase
        held = 1'b0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 60; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 60; end
                default: begin snd_idle_pct = 35; rcv_stall_pct = 35; end
            endcase
            program_regs((ph == 0) ? 16'd9 : 16'($urandom_range(10, 24)),
                         8'($urandom_range(255)), 16'($urandom_range(65535)),
                         16'($urandom_range(65535)));
            ph_bytes  = 0;
            ph_bodies = 0;
            while (ph_bytes < 40 || ph_bodies < 2) begin
                // once: sender holds until every verdict is out
                if (ph == 1 && ph_bodies == 1 && !held) begin
                    settle();
                    held = 1'b1;
                end
                d.hf        = HF_NONE;
                d.nblk      = ($urandom_range(19) == 0) ? $urandom_range(1, 32)
                                                        : $urandom_range(1, 4);
                d.crc_bad   = '0;
                d.magic_bad = '0;
                d.hdr_diff  = '0;
                for (k = 0; k < 32; k++) begin
                    d.crc_bad[k]   = ($urandom_range(99) < 10);
                    d.magic_bad[k] = ($urandom_range(99) < 10);
                    d.hdr_diff[k]  = ($urandom_range(99) < 8);
                end
                d.trail = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
                d.cut   = 0;
                d.seq   = $urandom;
                d.prof  = 8'($urandom_range(255));
                d.tag   = 16'($urandom_range(65535));
                r = $urandom_range(99);
                if (r < 70)
                    build_body(d);
                else if (r < 80) begin
                    // broken outer header
                    case ($urandom_range(2))
                        0: d.hf = HF_STREAM;
                        1: d.hf = HF_LEN;
                        default: begin
                            d.hf   = HF_COUNT;
                            d.nblk = $urandom_range(1) ? 0 : $urandom_range(33, 255);
                        end
                    endcase
                    build_body(d);
                end
                else if (r < 90) begin
                    // body that ends early
                    build_body(d);
                    k = $urandom_range(1, body_q.size() - 1);
                    while (body_q.size() > k)
                        void'(body_q.pop_back());
                end
                else begin
                    // noise
                    body_q.delete();
                    k = $urandom_range(1, 40);
                    while (body_q.size() < k)
                        body_q.insert(body_q.size(), 8'($urandom_range(255)));
                end
                ph_bytes += body_q.size();
                send_body();
                ph_bodies++;
            end
        end

        settle();
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS probe_body_checker_unit");
        else
            $display("FAIL probe_body_checker_unit");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL probe_body_checker_unit");
        $finish;
    end

endmodule
